// ===== rtl/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg: shared types, codes and constants of the token scanner
// Token kinds, error codes, scan modes and the result record.
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int LINE_BITS   = 16;
	localparam int OUT_BITS    = 16;

	localparam logic [5:0] K_ERR      = 6'd0;
	localparam logic [5:0] K_DOT      = 6'd5;
	localparam logic [5:0] K_SLASH    = 6'd9;
	localparam logic [5:0] K_BANG     = 6'd11;
	localparam logic [5:0] K_IDENT    = 6'd19;
	localparam logic [5:0] K_STRING   = 6'd20;
	localparam logic [5:0] K_NUMBER   = 6'd21;
	localparam logic [5:0] K_KEYWORD0 = 6'd22;
	localparam logic [5:0] K_EOF      = 6'd38;

	localparam logic [1:0] E_NONE     = 2'd0;
	localparam logic [1:0] E_UNEXPECT = 2'd1;
	localparam logic [1:0] E_UNTERM   = 2'd2;

	typedef enum logic [9:0] {
		M_IDLE    = 10'b0000000001,
		M_IDENT   = 10'b0000000010,
		M_INT     = 10'b0000000100,
		M_DOT     = 10'b0000001000,
		M_FRAC    = 10'b0000010000,
		M_STRING  = 10'b0000100000,
		M_OPER    = 10'b0001000000,
		M_SLASH   = 10'b0010000000,
		M_COMMENT = 10'b0100000000,
		M_ERROR   = 10'b1000000000
	} mode_t;

	typedef struct packed {
		logic [5:0]          kind;
		logic [1:0]          err;
		logic [OUT_BITS-1:0] start;
		logic [OUT_BITS-1:0] len;
		logic [OUT_BITS-1:0] line;
		logic                last;
	} tok_t;

	typedef struct packed {
		tok_t [2:0] tok;
		logic [1:0] cnt;
	} burst_t;

	function automatic logic [OUT_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
		logic [OFFSET_BITS:0] w;
		w = {1'b0, v};
		if (w > (OFFSET_BITS+1)'((1 << OUT_BITS) - 1))
			return '1;
		return OUT_BITS'(w);
	endfunction

	function automatic logic [OUT_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
		logic [LINE_BITS:0] w;
		w = {1'b0, v};
		if (w > (LINE_BITS+1)'((1 << OUT_BITS) - 1))
			return '1;
		return OUT_BITS'(w);
	endfunction

	function automatic logic [5:0] word_kind(input logic [47:0] buf_v, input logic [2:0] n);
		logic [5:0] k;
		k = K_IDENT;
		case ({n, buf_v})
			{3'd3, 48'h0000_0061_6e64}: k = K_KEYWORD0 + 6'd0;
			{3'd5, 48'h0063_6c61_7373}: k = K_KEYWORD0 + 6'd1;
			{3'd4, 48'h0000_656c_7365}: k = K_KEYWORD0 + 6'd2;
			{3'd5, 48'h0066_616c_7365}: k = K_KEYWORD0 + 6'd3;
			{3'd3, 48'h0000_0066_6f72}: k = K_KEYWORD0 + 6'd4;
			{3'd3, 48'h0000_0066_756e}: k = K_KEYWORD0 + 6'd5;
			{3'd2, 48'h0000_0000_6966}: k = K_KEYWORD0 + 6'd6;
			{3'd3, 48'h0000_006e_696c}: k = K_KEYWORD0 + 6'd7;
			{3'd2, 48'h0000_0000_6f72}: k = K_KEYWORD0 + 6'd8;
			{3'd5, 48'h0070_7269_6e74}: k = K_KEYWORD0 + 6'd9;
			{3'd6, 48'h7265_7475_726e}: k = K_KEYWORD0 + 6'd10;
			{3'd5, 48'h0073_7570_6572}: k = K_KEYWORD0 + 6'd11;
			{3'd4, 48'h0000_7468_6973}: k = K_KEYWORD0 + 6'd12;
			{3'd4, 48'h0000_7472_7565}: k = K_KEYWORD0 + 6'd13;
			{3'd3, 48'h0000_0076_6172}: k = K_KEYWORD0 + 6'd14;
			{3'd5, 48'h0077_6869_6c65}: k = K_KEYWORD0 + 6'd15;
			default: k = K_IDENT;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/lts_core.sv =====
// ----------------------------------------------------------------------------
// lts_core: scanner state and per-byte token logic
// Takes one byte or end item a cycle while step is high, updates state, yields up to three tokens.
// ----------------------------------------------------------------------------
module lts_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [7:0]                          source_byte,
	input  logic                                end_of_source,
	output lts_pkg::burst_t                     burst
);

	lts_pkg::mode_t                       mode_q, mode_d;
	logic [1:0]                           pop_q, pop_d;
	logic [lts_pkg::OFFSET_BITS-1:0]      pos_q, pos_d, start_q, start_d;
	logic [lts_pkg::LINE_BITS-1:0]        line_q, line_d;
	logic [47:0]                          kbuf_q, kbuf_d;
	logic [2:0]                           wlen_q, wlen_d;

	logic [lts_pkg::OFFSET_BITS-1:0]      p, nxt, dpos, one_len;
	logic [lts_pkg::LINE_BITS-1:0]        line_inc, line_fl;
	logic                                 rescan, alpha, digit;
	logic [3:0]                           pk;
	lts_pkg::tok_t [2:0]                  t;
	logic [1:0]                           n;

	function automatic lts_pkg::tok_t mk(input logic [5:0] k, input logic [1:0] e,
		input logic [lts_pkg::OFFSET_BITS-1:0] s, input logic [lts_pkg::OFFSET_BITS-1:0] l,
		input logic [lts_pkg::LINE_BITS-1:0] ln);
		lts_pkg::tok_t r;
		r.kind  = k;
		r.err   = e;
		r.start = lts_pkg::sat_off(s);
		r.len   = lts_pkg::sat_off(l);
		r.line  = lts_pkg::sat_line(ln);
		r.last  = 1'b0;
		return r;
	endfunction

	always_comb begin
		case (source_byte)
			8'h28: pk = 4'd0;
			8'h29: pk = 4'd1;
			8'h7b: pk = 4'd2;
			8'h7d: pk = 4'd3;
			8'h2c: pk = 4'd4;
			8'h2e: pk = 4'd5;
			8'h2d: pk = 4'd6;
			8'h2b: pk = 4'd7;
			8'h3b: pk = 4'd8;
			8'h2a: pk = 4'd10;
			default: pk = 4'd15;
		endcase
	end

	assign p        = pos_q;
	assign one_len  = lts_pkg::OFFSET_BITS'(1);
	assign nxt      = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
	assign line_inc = (line_q != '1) ? line_q + 1'b1 : line_q;
	assign alpha    = (source_byte >= 8'h61 && source_byte <= 8'h7a) ||
		(source_byte >= 8'h41 && source_byte <= 8'h5a) || source_byte == 8'h5f;
	assign digit    = source_byte >= 8'h30 && source_byte <= 8'h39;
	assign dpos     = (p > start_q) ? p - 1'b1 : start_q;

	always_comb begin
		mode_d = mode_q;
		pop_d  = pop_q;
		pos_d  = nxt;
		start_d = start_q;
		line_d = line_q;
		kbuf_d = kbuf_q;
		wlen_d = wlen_q;
		rescan = 1'b0;
		line_fl = line_q;
		t = '0;
		n = 2'd0;
		if (end_of_source) begin
			if (mode_q == lts_pkg::M_STRING) begin
				t[0] = mk(lts_pkg::K_ERR, lts_pkg::E_UNTERM, start_q, p - start_q, line_q);
				n = 2'd1;
			end else begin
				case (mode_q)
					lts_pkg::M_IDENT: begin
						t[0] = mk(lts_pkg::word_kind(kbuf_q, wlen_q), lts_pkg::E_NONE,
							start_q, p - start_q, line_q);
						n = 2'd1;
					end
					lts_pkg::M_INT, lts_pkg::M_FRAC: begin
						t[0] = mk(lts_pkg::K_NUMBER, lts_pkg::E_NONE, start_q, p - start_q, line_q);
						n = 2'd1;
					end
					lts_pkg::M_DOT: begin
						t[0] = mk(lts_pkg::K_NUMBER, lts_pkg::E_NONE, start_q, dpos - start_q,
							line_q);
						t[1] = mk(lts_pkg::K_DOT, lts_pkg::E_NONE, dpos, one_len, line_q);
						n = 2'd2;
					end
					lts_pkg::M_OPER: begin
						t[0] = mk(lts_pkg::K_BANG + {3'd0, pop_q, 1'b0}, lts_pkg::E_NONE,
							start_q, one_len, line_q);
						n = 2'd1;
					end
					lts_pkg::M_SLASH: begin
						t[0] = mk(lts_pkg::K_SLASH, lts_pkg::E_NONE, start_q, one_len, line_q);
						n = 2'd1;
					end
					default: n = 2'd0;
				endcase
			end
			t[n] = mk(lts_pkg::K_EOF, lts_pkg::E_NONE, p, '0, line_q);
			t[n].last = 1'b1;
			n = n + 2'd1;
			mode_d = lts_pkg::M_IDLE;
			pop_d = '0;
			pos_d = '0;
			start_d = '0;
			line_d = lts_pkg::LINE_BITS'(1);
			kbuf_d = '0;
			wlen_d = '0;
		end else begin
			case (mode_q)
				lts_pkg::M_IDENT:
					if (alpha || digit) begin
						if (wlen_q < 3'd6) kbuf_d = {kbuf_q[39:0], source_byte};
						if (wlen_q < 3'd7) wlen_d = wlen_q + 3'd1;
					end else rescan = 1'b1;
				lts_pkg::M_INT:
					if (source_byte == 8'h2e) mode_d = lts_pkg::M_DOT;
					else if (!digit) rescan = 1'b1;
				lts_pkg::M_DOT:
					if (digit) mode_d = lts_pkg::M_FRAC; else rescan = 1'b1;
				lts_pkg::M_FRAC:
					if (!digit) rescan = 1'b1;
				lts_pkg::M_STRING:
					if (source_byte == 8'h0a) line_d = line_inc;
					else if (source_byte == 8'h22) begin
						t[0] = mk(lts_pkg::K_STRING, lts_pkg::E_NONE, start_q, nxt - start_q,
							line_q);
						n = 2'd1;
						mode_d = lts_pkg::M_IDLE;
					end
				lts_pkg::M_OPER:
					if (source_byte == 8'h3d) begin
						t[0] = mk(lts_pkg::K_BANG + 6'd1 + {3'd0, pop_q, 1'b0}, lts_pkg::E_NONE,
							start_q, nxt - start_q, line_q);
						n = 2'd1;
						mode_d = lts_pkg::M_IDLE;
					end else rescan = 1'b1;
				lts_pkg::M_SLASH:
					if (source_byte == 8'h2f) mode_d = lts_pkg::M_COMMENT; else rescan = 1'b1;
				lts_pkg::M_COMMENT:
					if (source_byte == 8'h0a) begin
						mode_d = lts_pkg::M_IDLE;
						line_d = line_inc;
					end
				lts_pkg::M_ERROR: ;
				default: rescan = 1'b1;
			endcase
			if (rescan) begin
				case (mode_q)
					lts_pkg::M_IDENT: begin
						t[0] = mk(lts_pkg::word_kind(kbuf_q, wlen_q), lts_pkg::E_NONE,
							start_q, p - start_q, line_q);
						n = 2'd1;
					end
					lts_pkg::M_INT, lts_pkg::M_FRAC: begin
						t[0] = mk(lts_pkg::K_NUMBER, lts_pkg::E_NONE, start_q, p - start_q, line_q);
						n = 2'd1;
					end
					lts_pkg::M_DOT: begin
						t[0] = mk(lts_pkg::K_NUMBER, lts_pkg::E_NONE, start_q, dpos - start_q,
							line_q);
						t[1] = mk(lts_pkg::K_DOT, lts_pkg::E_NONE, dpos, one_len, line_q);
						n = 2'd2;
					end
					lts_pkg::M_OPER: begin
						t[0] = mk(lts_pkg::K_BANG + {3'd0, pop_q, 1'b0}, lts_pkg::E_NONE,
							start_q, one_len, line_q);
						n = 2'd1;
					end
					lts_pkg::M_SLASH: begin
						t[0] = mk(lts_pkg::K_SLASH, lts_pkg::E_NONE, start_q, one_len, line_q);
						n = 2'd1;
					end
					default: n = 2'd0;
				endcase
				mode_d = lts_pkg::M_IDLE;
				if (alpha) begin
					start_d = p; mode_d = lts_pkg::M_IDENT;
					kbuf_d = {40'd0, source_byte}; wlen_d = 3'd1;
				end else if (digit) begin
					start_d = p; mode_d = lts_pkg::M_INT;
				end else if (source_byte == 8'h20 || source_byte == 8'h0d ||
					source_byte == 8'h09) begin
					mode_d = lts_pkg::M_IDLE;
				end else if (source_byte == 8'h0a) begin
					line_d = line_inc;
				end else if (source_byte == 8'h2f) begin
					start_d = p; mode_d = lts_pkg::M_SLASH;
				end else if (source_byte == 8'h22) begin
					start_d = p; mode_d = lts_pkg::M_STRING;
				end else if (source_byte == 8'h21 || source_byte == 8'h3d ||
					source_byte == 8'h3e || source_byte == 8'h3c) begin
					start_d = p; mode_d = lts_pkg::M_OPER;
					pop_d = (source_byte == 8'h21) ? 2'd0 : (source_byte == 8'h3d) ? 2'd1 :
						(source_byte == 8'h3e) ? 2'd2 : 2'd3;
				end else if (pk != 4'd15) begin
					t[n] = mk({2'd0, pk}, lts_pkg::E_NONE, p, one_len, line_fl);
					n = n + 2'd1;
				end else begin
					t[n] = mk(lts_pkg::K_ERR, lts_pkg::E_UNEXPECT, p, one_len, line_fl);
					n = n + 2'd1;
					mode_d = lts_pkg::M_ERROR;
				end
			end
			if (n != 2'd0) t[n - 2'd1].last = 1'b1;
		end
		burst.tok = t;
		burst.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lts_pkg::M_IDLE;
			pop_q   <= '0;
			pos_q   <= '0;
			start_q <= '0;
			line_q  <= lts_pkg::LINE_BITS'(1);
			kbuf_q  <= '0;
			wlen_q  <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			pop_q   <= pop_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			line_q  <= line_d;
			kbuf_q  <= kbuf_d;
			wlen_q  <= wlen_d;
		end
	end

endmodule

// ===== rtl/lts_outq.sv =====
// ----------------------------------------------------------------------------
// lts_outq: result buffer
// Holds up to three tokens of one byte and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module lts_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  lts_pkg::burst_t burst,
	output logic            empty_next,
	output logic            out_valid,
	input  logic            out_ready,
	output lts_pkg::tok_t   head
);

	lts_pkg::tok_t [2:0] tok_q;
	logic [1:0]          cnt_q, rd_q;
	logic                pop, last_pop;

	assign out_valid  = cnt_q != 2'd0;
	assign pop        = out_valid && out_ready;
	assign last_pop   = pop && (rd_q + 2'd1 == cnt_q);
	assign empty_next = !out_valid || last_pop;
	assign head       = tok_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= burst.cnt;
			rd_q  <= '0;
		end else if (last_pop) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (pop) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) tok_q <= burst.tok;
	end

endmodule

// ===== rtl/lts_in_reg.sv =====
// ----------------------------------------------------------------------------
// lts_in_reg: input register
// Captures one source beat and holds it until the scanner consumes it.
// ----------------------------------------------------------------------------
module lts_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	input  logic       take,
	output logic       full,
	output logic [7:0] byte_s1,
	output logic       end_s1
);

	logic full_q;

	assign full     = full_q;
	assign in_ready = !full_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (in_ready) full_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			end_s1  <= in_end;
		end
	end

endmodule

// ===== rtl/lox_token_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// lox_token_scanner_unit: streaming source-text token scanner
// Input beat: source_byte with end_of_source; output beat: one token.
// ----------------------------------------------------------------------------
// Usage: stream source bytes on the input channel (valid/ready), one beat per
// byte, then one beat with end_of_source high to flush and emit end-of-file.
// Each result beat carries token_kind, error_code, start_offset, token_length,
// line_number, and last marks the final token caused by one input beat.
// Flow: a byte lands in the input register, is scanned when the result buffer
// can take its tokens, and its tokens are registered there and offered in order.
// Throughput: one byte per cycle while the receiver is ready and each byte
// gives at most one token; a byte that gives two or three tokens holds the
// input until its earlier tokens leave the single output port of the result buffer.
// Reset clears all scan state: offset 0, line 1, no token pending.
// When the receiver stalls, the result buffer holds, the scanner waits, and
// ready drops once the input register is full.
// ----------------------------------------------------------------------------
module lox_token_scanner_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   source_byte,
	input  logic                         end_of_source,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [5:0]                   token_kind,
	output logic [1:0]                   error_code,
	output logic [lts_pkg::OUT_BITS-1:0] start_offset,
	output logic [lts_pkg::OUT_BITS-1:0] token_length,
	output logic [lts_pkg::OUT_BITS-1:0] line_number,
	output logic                         last
);

	logic            full, take, empty_next;
	logic [7:0]      byte_s1;
	logic            end_s1;
	lts_pkg::burst_t burst;
	lts_pkg::tok_t   head;

	assign take = full && empty_next;

	lts_in_reg u_in (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_byte(source_byte), .in_end(end_of_source), .take(take), .full(full),
		.byte_s1(byte_s1), .end_s1(end_s1)
	);

	lts_core u_core (
		.clk(clk), .arst_n(arst_n), .step(take), .source_byte(byte_s1),
		.end_of_source(end_s1), .burst(burst)
	);

	lts_outq u_q (
		.clk(clk), .arst_n(arst_n), .load(take), .burst(burst),
		.empty_next(empty_next), .out_valid(out_valid), .out_ready(out_ready),
		.head(head)
	);

	assign token_kind   = head.kind;
	assign error_code   = head.err;
	assign start_offset = head.start;
	assign token_length = head.len;
	assign line_number  = head.line;
	assign last         = head.last;

endmodule

// ===== verif/lox_token_scanner_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lox_token_scanner_unit_tb: self-checking bench for the token scanner
// Streams directed and random source text through the valid/ready ports and
// checks every token beat against a behavioral scanner kept in the bench.
// ----------------------------------------------------------------------------
module lox_token_scanner_unit_tb;

	typedef struct packed {
		logic [5:0]  kind;
		logic [1:0]  err;
		logic [15:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic        last;
	} token_rec_t;

	typedef enum int {
		S_IDLE, S_IDENT, S_INT, S_DOT, S_FRAC, S_STRING, S_OPER, S_SLASH, S_COMMENT, S_ERROR
	} scan_st_t;

	typedef struct {
		logic [7:0] ch;
		logic       eos;
		logic       has_tok;
		token_rec_t tok;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  source_byte;
	logic        end_of_source;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  token_kind;
	logic [1:0]  error_code;
	logic [15:0] start_offset;
	logic [15:0] token_length;
	logic [15:0] line_number;
	logic        last;

	lox_token_scanner_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.source_byte(source_byte), .end_of_source(end_of_source),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .error_code(error_code),
		.start_offset(start_offset), .token_length(token_length),
		.line_number(line_number), .last(last)
	);

	token_rec_t  pending_tokens[$];
	int          fail_count;
	int          send_idle_pct;
	int          recv_idle_pct;

	scan_st_t    sc_mode;
	logic [1:0]  sc_op;
	logic [15:0] sc_pos;
	logic [15:0] sc_start;
	logic [15:0] sc_line;
	logic [47:0] sc_word;
	logic [2:0]  sc_wlen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("lox_token_scanner_unit regression: fail");
		$finish;
	end

	function automatic bit is_alpha_ch(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_digit_ch(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [5:0] keyword_kind(logic [47:0] w, logic [2:0] n);
		string words[16];
		logic [47:0] packed_w;
		words = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
			"or", "print", "return", "super", "this", "true", "var", "while"};
		for (int k = 0; k < 16; k++) begin
			packed_w = '0;
			for (int i = 0; i < words[k].len(); i++)
				packed_w = {packed_w[39:0], words[k][i]};
			if (words[k].len() == n && packed_w == w)
				return lts_pkg::K_KEYWORD0 + 6'(k);
		end
		return lts_pkg::K_IDENT;
	endfunction

	function automatic int punct_kind(logic [7:0] c);
		case (c)
			"(": return 0;
			")": return 1;
			"{": return 2;
			"}": return 3;
			",": return 4;
			".": return 5;
			"-": return 6;
			"+": return 7;
			";": return 8;
			"*": return 10;
			default: return -1;
		endcase
	endfunction

	task automatic push_token(logic [5:0] k, logic [1:0] e, logic [15:0] s, logic [15:0] n);
		token_rec_t t;
		t.kind = k; t.err = e; t.start = s; t.len = n; t.line = sc_line; t.last = 1'b0;
		pending_tokens.push_back(t);
	endtask

	task automatic scanner_reset();
		sc_mode = S_IDLE; sc_op = '0; sc_pos = '0; sc_start = '0;
		sc_line = 16'd1; sc_word = '0; sc_wlen = '0;
	endtask

	task automatic scan_fresh(logic [7:0] c, logic [15:0] p);
		int pk;
		pk = punct_kind(c);
		if (is_alpha_ch(c)) begin
			sc_start = p; sc_mode = S_IDENT; sc_word = {40'd0, c}; sc_wlen = 3'd1;
		end else if (is_digit_ch(c)) begin
			sc_start = p; sc_mode = S_INT;
		end else if (c == " " || c == 8'h0d || c == 8'h09) begin
		end else if (c == 8'h0a) begin
			if (sc_line != 16'hffff) sc_line++;
		end else if (c == "/") begin
			sc_start = p; sc_mode = S_SLASH;
		end else if (c == 8'h22) begin
			sc_start = p; sc_mode = S_STRING;
		end else if (c == "!" || c == "=" || c == ">" || c == "<") begin
			sc_start = p; sc_mode = S_OPER;
			sc_op = c == "!" ? 2'd0 : c == "=" ? 2'd1 : c == ">" ? 2'd2 : 2'd3;
		end else if (pk >= 0) begin
			push_token(6'(pk), lts_pkg::E_NONE, p, 16'd1);
		end else begin
			push_token(lts_pkg::K_ERR, lts_pkg::E_UNEXPECT, p, 16'd1);
			sc_mode = S_ERROR;
		end
	endtask

	task automatic flush_word(logic [15:0] p);
		logic [15:0] dpos;
		case (sc_mode)
			S_IDENT: push_token(keyword_kind(sc_word, sc_wlen), lts_pkg::E_NONE, sc_start,
				p - sc_start);
			S_INT, S_FRAC: push_token(lts_pkg::K_NUMBER, lts_pkg::E_NONE, sc_start, p - sc_start);
			S_DOT: begin
				dpos = p > sc_start ? p - 16'd1 : sc_start;
				push_token(lts_pkg::K_NUMBER, lts_pkg::E_NONE, sc_start, dpos - sc_start);
				push_token(lts_pkg::K_DOT, lts_pkg::E_NONE, dpos, 16'd1);
			end
			S_OPER: push_token(lts_pkg::K_BANG + 6'(2 * sc_op), lts_pkg::E_NONE, sc_start, 16'd1);
			S_SLASH: push_token(lts_pkg::K_SLASH, lts_pkg::E_NONE, sc_start, 16'd1);
			default: ;
		endcase
		sc_mode = S_IDLE;
	endtask

	task automatic predict_tokens(logic [7:0] c, logic eos);
		int          before_n;
		logic [15:0] p;
		logic [15:0] nxt;
		bit          rescan;
		before_n = pending_tokens.size();
		p = sc_pos;
		rescan = 0;
		if (eos) begin
			if (sc_mode == S_STRING)
				push_token(lts_pkg::K_ERR, lts_pkg::E_UNTERM, sc_start, p - sc_start);
			else flush_word(p);
			push_token(lts_pkg::K_EOF, lts_pkg::E_NONE, p, 16'd0);
			pending_tokens[$].last = 1'b1;
			scanner_reset();
			return;
		end
		nxt = p != 16'hffff ? p + 16'd1 : p;
		case (sc_mode)
			S_IDENT: begin
				if (is_alpha_ch(c) || is_digit_ch(c)) begin
					if (sc_wlen < 6) sc_word = {sc_word[39:0], c};
					if (sc_wlen < 7) sc_wlen++;
				end else rescan = 1;
			end
			S_INT: begin
				if (c == ".") sc_mode = S_DOT;
				else if (!is_digit_ch(c)) rescan = 1;
			end
			S_DOT: begin
				if (is_digit_ch(c)) sc_mode = S_FRAC; else rescan = 1;
			end
			S_FRAC: if (!is_digit_ch(c)) rescan = 1;
			S_STRING: begin
				if (c == 8'h0a) begin
					if (sc_line != 16'hffff) sc_line++;
				end else if (c == 8'h22) begin
					push_token(lts_pkg::K_STRING, lts_pkg::E_NONE, sc_start, nxt - sc_start);
					sc_mode = S_IDLE;
				end
			end
			S_OPER: begin
				if (c == "=") begin
					push_token(lts_pkg::K_BANG + 6'(2 * sc_op + 1), lts_pkg::E_NONE, sc_start,
						nxt - sc_start);
					sc_mode = S_IDLE;
				end else rescan = 1;
			end
			S_SLASH: begin
				if (c == "/") sc_mode = S_COMMENT; else rescan = 1;
			end
			S_COMMENT: begin
				if (c == 8'h0a) begin
					sc_mode = S_IDLE;
					scan_fresh(c, p);
				end
			end
			S_ERROR: ;
			default: begin
				sc_mode = S_IDLE;
				scan_fresh(c, p);
			end
		endcase
		if (rescan) begin
			flush_word(p);
			scan_fresh(c, p);
		end
		sc_pos = nxt;
		if (pending_tokens.size() > before_n) pending_tokens[$].last = 1'b1;
	endtask

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	// result side: random stall, compare each beat with the oldest expectation
	always @(posedge clk) begin
		token_rec_t t;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tokens.size() == 0) begin
				$error("token beat with no expectation: kind %0d", token_kind);
				fail_count++;
			end else begin
				t = pending_tokens.pop_front();
				check_field("token_kind", 16'(t.kind), 16'(token_kind));
				check_field("error_code", 16'(t.err), 16'(error_code));
				check_field("start_offset", t.start, start_offset);
				check_field("token_length", t.len, token_length);
				check_field("line_number", t.line, line_number);
				check_field("last", 16'(t.last), 16'(last));
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_beat(logic [7:0] c, logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		source_byte <= c;
		end_of_source <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_tokens(c, eos);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
	endtask

	task automatic drain_tokens();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_tokens.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_tokens.size() != 0) begin
			$display("lox_token_scanner_unit regression: fail");
			$finish;
		end
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		string alpha;
		alpha = "abcdefghilnoprstuvwxyzAZ_019.()/{},-+;*!=<>\" \n\t\r";
		case ($urandom_range(19))
			0: return 8'($urandom_range(255));
			default: return alpha[$urandom_range(alpha.len() - 1)];
		endcase
	endfunction

	task automatic send_random_text(int n);
		string frags[12];
		string f;
		int i;
		frags = '{"and ", "class", "while", "return(", "12.5", "7.x", "3.", "\"ab\ncd\"",
			"// note\n", "!= ", "<=>", "returns"};
		i = 0;
		while (i < n) begin
			if ($urandom_range(2) == 0) begin
				f = frags[$urandom_range(11)];
				send_text(f);
				i += f.len();
			end else begin
				send_beat(pick_char(), 1'b0);
				i++;
			end
		end
		send_beat(8'($urandom_range(255)), 1'b1);
	endtask

	stim_row_t directed_rows[$];

	task automatic add_row(logic [7:0] c, logic eos, logic has_tok = 0,
			token_rec_t t = '0);
		stim_row_t r;
		r.ch = c; r.eos = eos; r.has_tok = has_tok; r.tok = t;
		directed_rows.push_back(r);
	endtask

	initial begin
		token_rec_t t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		source_byte = '0;
		end_of_source = 1'b0;
		out_ready = 1'b0;
		fail_count = 0;
		send_idle_pct = 16;
		recv_idle_pct = 82;
		scanner_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: end after reset, punctuation, bad bytes, numbers with a dot
		t = '{lts_pkg::K_EOF, lts_pkg::E_NONE, 16'd0, 16'd0, 16'd1, 1'b1};
		add_row(8'hff, 1'b1, 1, t);
		t = '{6'd0, lts_pkg::E_NONE, 16'd0, 16'd1, 16'd1, 1'b1};
		add_row("(", 1'b0, 1, t);
		add_row("1", 1'b0); add_row(".", 1'b0); add_row("a", 1'b0);
		add_row("1", 1'b0); add_row(".", 1'b0); add_row("5", 1'b0);
		add_row("9", 1'b0); add_row(".", 1'b0); add_row(8'h00, 1'b1);
		add_row("!", 1'b0); add_row("=", 1'b0); add_row("<", 1'b0);
		add_row(8'h22, 1'b0); add_row(8'h0a, 1'b0); add_row(8'h80, 1'b1);
		t = '{lts_pkg::K_ERR, lts_pkg::E_UNEXPECT, 16'd0, 16'd1, 16'd1, 1'b1};
		add_row(8'hff, 1'b0, 1, t);
		add_row("a", 1'b0); add_row(8'h00, 1'b1);
		add_row(8'h0b, 1'b0); add_row(8'h7f, 1'b0); add_row(8'h01, 1'b1);
		foreach (directed_rows[i]) begin
			if (directed_rows[i].has_tok) begin
				send_beat(directed_rows[i].ch, directed_rows[i].eos);
				if (pending_tokens.size() == 0 ||
						pending_tokens[$] != directed_rows[i].tok) begin
					$error("directed row %0d: bench scanner disagrees with table", i);
					fail_count++;
				end
			end else
				send_beat(directed_rows[i].ch, directed_rows[i].eos);
		end
		send_text("and class else false for fun if nil or print return super this");
		send_text(" true var while whiles _x9 >= > == = // c\n/ / { } , - + ; *");
		send_beat(8'h00, 1'b1);
		drain_tokens();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 16 : ph == 1 ? 82 : 0;
			recv_idle_pct = ph == 0 ? 82 : ph == 1 ? 16 : 0;
			for (int k = 0; k < 3; k++) send_random_text($urandom_range(10, 30));
			drain_tokens();
		end
		send_idle_pct = 0;
		send_random_text(20);
		drain_tokens();

		if (fail_count == 0)
			$display("lox_token_scanner_unit regression: pass");
		else
			$display("lox_token_scanner_unit regression: fail");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/lts_pkg.sv
rtl/lts_core.sv
rtl/lts_outq.sv
rtl/lts_in_reg.sv
rtl/lox_token_scanner_unit.sv
verif/lox_token_scanner_unit_tb.sv
